>>> sv/lcg_random_generator_core_assert.svh
// ----------------------------------------------------------------------------
// lcg_random_generator_core_assert.svh
// assertion macros shared by the generator rtl, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef LCG_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define LCG_RANDOM_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define LCG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lcg_rng_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_rng_pkg
// shared widths, register indexes, mode codes and reset values of the
// congruential generator
// ----------------------------------------------------------------------------
package lcg_rng_pkg;

  // configuration register width and index width
  localparam int REG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int MODE_BITS      = 2;

  // default result widths
  localparam int DEF_VALUE_BITS    = 16;
  localparam int DEF_FRACTION_BITS = 16;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MULTIPLIER  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INCREMENT   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEED_FIRST  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEED_SECOND = 3'd5;

  // generator modes
  localparam logic [MODE_BITS-1:0] MODE_MIXED  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_MULT   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_ADD    = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_LAGGED = 2'd3;

  // register reset values
  localparam logic [MODE_BITS-1:0] RST_MODE       = MODE_MIXED;
  localparam logic [REG_BITS-1:0]  RST_MULTIPLIER = 16'd1;
  localparam logic [REG_BITS-1:0]  RST_INCREMENT  = 16'd0;
  localparam logic [REG_BITS-1:0]  RST_MODULUS    = 16'd65535;
  localparam logic [REG_BITS-1:0]  RST_SEED       = 16'd1;

  // result of one restoring division step
  typedef struct packed {
    logic [REG_BITS-1:0] rem;
    logic                q;
  } div_step_t;

endpackage

>>> sv/lcg_rng_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_rng_div_step
// one restoring long-division step: shift in a bit, compare against the
// modulus and subtract when it fits; shared by the reduction and fraction
// ----------------------------------------------------------------------------
module lcg_rng_div_step (
  input  logic [lcg_rng_pkg::REG_BITS-1:0] rem_in,
  input  logic                             bit_in,
  input  logic [lcg_rng_pkg::REG_BITS-1:0] modulus,
  output lcg_rng_pkg::div_step_t           step_out
);

  logic [lcg_rng_pkg::REG_BITS:0] trial;
  logic [lcg_rng_pkg::REG_BITS:0] diff;
  logic                           fits;

  // partial remainder stays below the modulus, so the shifted trial fits
  assign trial = {rem_in, bit_in};
  assign diff  = trial - {1'b0, modulus};
  assign fits  = (trial >= {1'b0, modulus});

  always_comb begin
    step_out.q   = fits;
    step_out.rem = fits ? diff[lcg_rng_pkg::REG_BITS-1:0]
                        : trial[lcg_rng_pkg::REG_BITS-1:0];
  end

endmodule

>>> sv/lcg_random_generator_core.sv
`timescale 1ns / 1ps
`include "lcg_random_generator_core_assert.svh"
// ----------------------------------------------------------------------------
// lcg_random_generator_core
// congruential pseudo-random generator (mixed, multiplicative, additive and
// lagged additive) with value and floored Q0.FRACTION_BITS fraction x/m
//
//   channel | direction | handshake           | payload
//   in_     | in        | in_valid/in_ready   | in_restart
//   out_    | out       | out_valid/out_ready | out_value, out_fraction
//   cfg_    | in        | cfg_we              | cfg_index, cfg_wdata
//
// an item runs one multiply step, 32 reduction steps and FRACTION_BITS
// fraction steps on the single shared division-step unit, then the output
// load; the sequencer then returns to idle, where the next item is taken.
// in_ready is high only while the sequencer is idle.
// a finished result waits in the output register while the next item runs;
// the sequencer holds at its final step until that register is free.
// synchronous active-low reset; seeds load on the first item after reset.
// ----------------------------------------------------------------------------
module lcg_random_generator_core #(
  parameter int VALUE_BITS    = lcg_rng_pkg::DEF_VALUE_BITS,
  parameter int FRACTION_BITS = lcg_rng_pkg::DEF_FRACTION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_restart,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [VALUE_BITS-1:0]                  out_value,
  output logic [FRACTION_BITS-1:0]               out_fraction,
  // configuration port
  input  logic                                   cfg_we,
  input  logic [lcg_rng_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lcg_rng_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int RB       = lcg_rng_pkg::REG_BITS;
  localparam int DIV_BITS = 2 * RB;
  localparam int CNT_BITS = $clog2((DIV_BITS > FRACTION_BITS) ? DIV_BITS : FRACTION_BITS);
  localparam logic [RB-1:0] VALUE_MASK =
    (VALUE_BITS >= RB) ? {RB{1'b1}} : RB'((64'd1 << VALUE_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MOD,
    S_FRAC,
    S_DONE
  } state_t;

  // configuration registers
  logic [lcg_rng_pkg::MODE_BITS-1:0] mode_r;
  logic [RB-1:0]                     mult_r;
  logic [RB-1:0]                     incr_r;
  logic [RB-1:0]                     modulus_r;
  logic [RB-1:0]                     seed1_r;
  logic [RB-1:0]                     seed2_r;

  // sequencer and datapath
  state_t                  state_r, state_nxt;
  logic [CNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0]     div_r, div_nxt;
  logic [RB-1:0]           rem_r, rem_nxt;
  logic [RB-1:0]           val_r, val_nxt;
  logic [FRACTION_BITS-1:0] quot_r, quot_nxt;
  logic [RB-1:0]           newest_r, newest_nxt;
  logic [RB-1:0]           older_r, older_nxt;
  logic                    primed_r, primed_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0]   out_value_r, out_value_nxt;
  logic [FRACTION_BITS-1:0] out_fraction_r, out_fraction_nxt;

  logic [RB-1:0]           m_eff;
  logic [DIV_BITS-1:0]     prod;
  logic [DIV_BITS-1:0]     operand;
  logic                    step_bit;
  lcg_rng_pkg::div_step_t  step;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= lcg_rng_pkg::RST_MODE;
      mult_r    <= lcg_rng_pkg::RST_MULTIPLIER;
      incr_r    <= lcg_rng_pkg::RST_INCREMENT;
      modulus_r <= lcg_rng_pkg::RST_MODULUS;
      seed1_r   <= lcg_rng_pkg::RST_SEED;
      seed2_r   <= lcg_rng_pkg::RST_SEED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcg_rng_pkg::REG_MODE:        mode_r    <= cfg_wdata[lcg_rng_pkg::MODE_BITS-1:0];
        lcg_rng_pkg::REG_MULTIPLIER:  mult_r    <= cfg_wdata[RB-1:0];
        lcg_rng_pkg::REG_INCREMENT:   incr_r    <= cfg_wdata[RB-1:0];
        lcg_rng_pkg::REG_MODULUS:     modulus_r <= cfg_wdata[RB-1:0];
        lcg_rng_pkg::REG_SEED_FIRST:  seed1_r   <= cfg_wdata[RB-1:0];
        lcg_rng_pkg::REG_SEED_SECOND: seed2_r   <= cfg_wdata[RB-1:0];
        default: ;
      endcase
    end
  end

  // zero modulus behaves as one
  assign m_eff = (modulus_r == '0) ? RB'(1) : modulus_r;

  // recurrence operand, below 2^32 in every mode
  assign prod = DIV_BITS'(mult_r) * DIV_BITS'(newest_r);

  always_comb begin
    unique case (mode_r)
      lcg_rng_pkg::MODE_MIXED: operand = prod + DIV_BITS'(incr_r);
      lcg_rng_pkg::MODE_MULT:  operand = prod;
      lcg_rng_pkg::MODE_ADD:   operand = DIV_BITS'(newest_r) + DIV_BITS'(incr_r);
      default:                 operand = DIV_BITS'(older_r) + DIV_BITS'(newest_r);
    endcase
  end

  // shared division step: dividend bits while reducing, zeros for the fraction
  assign step_bit = (state_r == S_MOD) ? div_r[DIV_BITS-1] : 1'b0;

  lcg_rng_div_step u_div_step (
    .rem_in   (rem_r),
    .bit_in   (step_bit),
    .modulus  (m_eff),
    .step_out (step)
  );

  // sequencer next state
  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    div_nxt          = div_r;
    rem_nxt          = rem_r;
    val_nxt          = val_r;
    quot_nxt         = quot_r;
    newest_nxt       = newest_r;
    older_nxt        = older_r;
    primed_nxt       = primed_r;
    out_valid_nxt    = out_valid_r;
    out_value_nxt    = out_value_r;
    out_fraction_nxt = out_fraction_r;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // seed load on restart or first item
          if (in_restart || !primed_r) begin
            older_nxt  = seed1_r & VALUE_MASK;
            newest_nxt = ((mode_r == lcg_rng_pkg::MODE_LAGGED) ? seed2_r : seed1_r)
                         & VALUE_MASK;
            primed_nxt = 1'b1;
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        div_nxt   = operand;
        rem_nxt   = '0;
        cnt_nxt   = CNT_BITS'(DIV_BITS - 1);
        state_nxt = S_MOD;
      end
      S_MOD: begin
        rem_nxt = step.rem;
        div_nxt = {div_r[DIV_BITS-2:0], 1'b0};
        if (cnt_r == '0) begin
          // remainder is the new value; history shifts
          val_nxt    = step.rem;
          older_nxt  = newest_r;
          newest_nxt = step.rem & VALUE_MASK;
          cnt_nxt    = CNT_BITS'(FRACTION_BITS - 1);
          state_nxt  = S_FRAC;
        end else begin
          cnt_nxt = cnt_r - CNT_BITS'(1);
        end
      end
      S_FRAC: begin
        rem_nxt  = step.rem;
        quot_nxt = {quot_r[FRACTION_BITS-2:0], step.q};
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - CNT_BITS'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_value_nxt    = VALUE_BITS'(val_r);
          out_fraction_nxt = quot_r;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      newest_r    <= '0;
      older_r     <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      newest_r    <= newest_nxt;
      older_r     <= older_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    div_r          <= div_nxt;
    rem_r          <= rem_nxt;
    val_r          <= val_nxt;
    quot_r         <= quot_nxt;
    out_value_r    <= out_value_nxt;
    out_fraction_r <= out_fraction_nxt;
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_fraction = out_fraction_r;

  // checks
  `LCG_ASSERT_NOW(a_rem_below_mod, (state_r == S_MOD || state_r == S_FRAC), (rem_r < m_eff), "partial remainder not below modulus")
  `LCG_ASSERT_NOW(a_val_below_mod, (state_r == S_FRAC || state_r == S_DONE), (val_r < m_eff), "new value not below modulus")
  `LCG_ASSERT_NEXT(a_primed_after_accept, (in_valid && in_ready), (primed_r && state_r == S_MUL), "seeds not loaded after item accepted")
  `LCG_ASSERT_NEXT(a_mod_to_frac, (state_r == S_MOD && cnt_r == '0), (state_r == S_FRAC), "reduction did not hand over to fraction")
  `LCG_ASSERT_NEXT(a_done_holds, (state_r == S_DONE && out_valid_r && !out_ready), (state_r == S_DONE && out_valid_r), "pending result overwritten")

endmodule
